[hdl/b64d_pkg.sv]
// Shared types, constants and the character table of the base64 decoder.
package b64d_pkg;

	localparam logic [7:0] PAD_CHAR    = 8'h3D;
	localparam logic [5:0] SEXTET_62   = 6'd62;
	localparam logic [5:0] SEXTET_63   = 6'd63;
	localparam int         QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [23:0] word;
		logic [1:0]  nbytes;
		logic        last;
	} grp_t;

	typedef struct packed {
		logic valid;
		grp_t grp;
	} head_t;

	function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
		logic [5:0] s;
		s = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			s = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B || c == 8'h2D || c == 8'h2E) begin
			s = SEXTET_62;
		end else if (c == 8'h2F || c == 8'h5F || c == 8'h2C) begin
			s = SEXTET_63;
		end
		return s;
	endfunction

endpackage

[hdl/b64d_front.sv]
// Front end: maps characters to sextets, gathers groups and queues them.
module b64d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [7:0]        in_char,
	input  logic              is_last,
	output logic              push,
	output b64d_pkg::grp_t    push_grp
);

	logic [17:0] buf_q;
	logic [1:0]  cnt_q;
	logic        third_q;
	logic [5:0]  sextet;
	logic [23:0] held;
	logic        is_pad;
	logic        close;
	logic        accept;

	always_comb begin
		sextet = b64d_pkg::char_to_sextet(in_char);
		held   = {buf_q, sextet};
		is_pad = (in_char == b64d_pkg::PAD_CHAR);
		close  = is_last || (cnt_q == 2'd3);
		accept = in_valid && !in_stall;
		case (cnt_q)
			2'd0:    push_grp.word = {held[5:0], 18'd0};
			2'd1:    push_grp.word = {held[11:0], 12'd0};
			2'd2:    push_grp.word = {held[17:0], 6'd0};
			default: push_grp.word = held;
		endcase
		if (!is_last) begin
			push_grp.nbytes = 2'd3;
		end else if (cnt_q == 2'd3 && !is_pad) begin
			push_grp.nbytes = 2'd3;
		end else begin
			push_grp.nbytes = 2'd1;
			if (cnt_q == 2'd2 && !is_pad) push_grp.nbytes = 2'd2;
			if (cnt_q == 2'd3 && !third_q) push_grp.nbytes = 2'd2;
		end
		push_grp.last = is_last;
		push          = accept && close;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q   <= '0;
			cnt_q   <= '0;
			third_q <= 1'b0;
		end else if (accept) begin
			if (close) begin
				buf_q   <= '0;
				cnt_q   <= '0;
				third_q <= 1'b0;
			end else begin
				buf_q <= held[17:0];
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd2) third_q <= is_pad;
			end
		end
	end

endmodule

[hdl/b64d_queue.sv]
// Short group queue between the front and back ends.
module b64d_queue #(
	parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  b64d_pkg::grp_t  push_grp,
	input  logic            pop,
	output b64d_pkg::head_t head,
	output logic            full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64d_pkg::grp_t entries_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.grp   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/b64d_back.sv]
// Back end: unpacks each queued group into bytes behind an output register.
module b64d_back (
	input  logic            clk,
	input  logic            arst_n,
	input  b64d_pkg::head_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       load;
	logic       final_byte;
	logic [7:0] sel_byte;

	always_comb begin
		load       = head.valid && (!out_valid_q || !out_stall);
		final_byte = (idx_q == head.grp.nbytes - 2'd1);
		pop        = load && final_byte;
		case (idx_q)
			2'd0:    sel_byte = head.grp.word[23:16];
			2'd1:    sel_byte = head.grp.word[15:8];
			default: sel_byte = head.grp.word[7:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= sel_byte;
			out_last_q <= head.grp.last && final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= final_byte ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

[hdl/base64url_decoder.sv]
// Top level of the lenient base64 / base64url decoder.
//
// Input channel: one character per transfer (in_char) with is_last marking
// the final character of a string. Output channel: one decoded byte per
// transfer (out_byte), out_last set on the final byte of the string.
// Both channels transfer when valid is high and stall is low.
// Throughput: one character per cycle while in_stall is low; a group of
// four characters yields three bytes, so the output, at most one byte per
// cycle, keeps pace with the input.
// Once a character closes a group, the group is pushed into the queue; with the
// output register free, its first byte is then loaded from the queue head into
// the output register, and the other bytes follow one per cycle unless stalled.
// The front end gathers sextets and pushes each closed group into a queue
// of QUEUE_DEPTH entries (the user keeps it at least two; not enforced);
// the back end unpacks the head group into a single output register. When
// the receiver stalls, the output register holds; once the queue fills,
// in_stall rises. Reset clears the open group, the queue and the output register.
module base64url_decoder #(
	parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic            push;
	b64d_pkg::grp_t  push_grp;
	logic            pop;
	b64d_pkg::head_t head;
	logic            full;

	assign in_stall = full;

	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (full),
		.in_char  (in_char),
		.is_last  (is_last),
		.push     (push),
		.push_grp (push_grp)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.head     (head),
		.full     (full)
	);

	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

[hdl/b64d_checker.sv]
// Port-level checks of the decoder and their binding to the top level.
module b64d_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_char,
	input logic       is_last,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       out_last
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_char) && $stable(is_last))
		else $error("stalled input changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("stalled output changed");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("output dropped without a transfer");

	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("output appeared from an empty pipeline");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled while the output register is empty");

endmodule

bind base64url_decoder b64d_checker u_b64d_checker (.*);
